@@ hdl/ltbg_pkg.sv @@
// Shared types, constants, font table and helper functions of the LCD text byte generator.
package ltbg_pkg;

  localparam int GLYPH_WIDTH = 5;
  localparam int DIGIT_COUNT = 4;
  localparam int GLYPH_COUNT = 95;
  localparam int BIN_W       = 14;
  localparam int BCD_W       = 4 * DIGIT_COUNT;
  localparam int WORK_W      = BCD_W + BIN_W;
  localparam int COL_W       = $clog2(GLYPH_WIDTH + 1);
  localparam int DIG_W       = $clog2(DIGIT_COUNT);
  localparam int GLYPH_W     = $clog2(GLYPH_COUNT);
  localparam int STEPS_MAX   = 5;
  localparam int STEPS_A     = 5;
  localparam int STEPS_B     = 5;
  localparam int STEPS_C     = BIN_W - STEPS_A - STEPS_B;

  localparam logic [7:0]         FIRST_CODE = 8'd32;
  localparam logic [7:0]         LAST_CODE  = 8'd126;
  localparam logic [BIN_W-1:0]   NUMBER_MAX = 14'd9999;
  localparam logic [7:0]         ASCII_ZERO = 8'd48;
  localparam logic [GLYPH_W-1:0] ZERO_GLYPH = GLYPH_W'(ASCII_ZERO - FIRST_CODE);
  localparam logic [7:0]         SET_COLUMN = 8'h80;
  localparam logic [7:0]         SET_ROW    = 8'h40;
  localparam logic [3:0]         DIGIT_MAX  = 4'd9;

  typedef enum logic [2:0] {
    CMD_RAW_CMD  = 3'd0,
    CMD_RAW_DATA = 3'd1,
    CMD_CHAR     = 3'd2,
    CMD_CURSOR   = 3'd3,
    CMD_NUMBER   = 3'd4
  } cmd_e;

  typedef struct packed {
    cmd_e              command;
    logic [7:0]        byte_value;
    logic [6:0]        column;
    logic [2:0]        row;
    logic [WORK_W-1:0] work;
  } stage_t;

  typedef struct packed {
    cmd_e             command;
    logic [7:0]       byte_value;
    logic [6:0]       column;
    logic [2:0]       row;
    logic [BCD_W-1:0] digits;
  } req_t;

  // Leftmost column in the top byte of each entry.
  localparam logic [39:0] GLYPH_ROM [GLYPH_COUNT] = '{
    40'h0000000000, 40'h00002f0000, 40'h0007000700, 40'h147f147f14, 40'h242a7f2a12,
    40'h6264081323, 40'h3649552250, 40'h0005030000, 40'h001c224100, 40'h0041221c00,
    40'h14083e0814, 40'h08083e0808, 40'h0000a06000, 40'h0808080808, 40'h0060600000,
    40'h2010080402, 40'h3e5149453e, 40'h00427f4000, 40'h4261514946, 40'h2141454b31,
    40'h1814127f10, 40'h2745454539, 40'h3c4a494930, 40'h0171090503, 40'h3649494936,
    40'h064949291e, 40'h0036360000, 40'h0056360000, 40'h0814224100, 40'h1414141414,
    40'h0041221408, 40'h0201510906, 40'h324959513e, 40'h7c1211127c, 40'h7f49494936,
    40'h3e41414122, 40'h7f4141221c, 40'h7f49494941, 40'h7f09090901, 40'h3e4149497a,
    40'h7f0808087f, 40'h00417f4100, 40'h2040413f01, 40'h7f08142241, 40'h7f40404040,
    40'h7f020c027f, 40'h7f0408107f, 40'h3e4141413e, 40'h7f09090906, 40'h3e4151215e,
    40'h7f09192946, 40'h4649494931, 40'h01017f0101, 40'h3f4040403f, 40'h1f2040201f,
    40'h3f4038403f, 40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007f414100,
    40'h552a552a55, 40'h0041417f00, 40'h0402010204, 40'h4040404040, 40'h0001020400,
    40'h2054545478, 40'h7f48444438, 40'h3844444420, 40'h384444487f, 40'h3854545418,
    40'h087e090102, 40'h18a4a4a47c, 40'h7f08040478, 40'h00447d4000, 40'h4080847d00,
    40'h7f10284400, 40'h00417f4000, 40'h7c04180478, 40'h7c08040478, 40'h3844444438,
    40'hfc24242418, 40'h18242418fc, 40'h7c08040408, 40'h4854545420, 40'h043f444020,
    40'h3c4040207c, 40'h1c2040201c, 40'h3c4030403c, 40'h4428102844, 40'h1ca0a0a07c,
    40'h4464544c44, 40'h0008364100, 40'h00007f0000, 40'h0041360800, 40'h0810080408
  };

  function automatic logic [WORK_W-1:0] dabble_step(input logic [WORK_W-1:0] w);
    logic [WORK_W-1:0] t;
    t = w;
    for (int i = 0; i < DIGIT_COUNT; i++) begin
      if (t[BIN_W+4*i +: 4] >= 4'd5) begin
        t[BIN_W+4*i +: 4] = t[BIN_W+4*i +: 4] + 4'd3;
      end
    end
    return {t[WORK_W-2:0], 1'b0};
  endfunction

  function automatic logic [WORK_W-1:0] dabble_run(input logic [WORK_W-1:0] w,
                                                   input int n);
    logic [WORK_W-1:0] t;
    t = w;
    for (int i = 0; i < STEPS_MAX; i++) begin
      if (i < n) begin
        t = dabble_step(t);
      end
    end
    return t;
  endfunction

  function automatic logic [GLYPH_W-1:0] glyph_index(input logic [7:0] code);
    logic [7:0] off;
    off = code - FIRST_CODE;
    if (code >= FIRST_CODE && code <= LAST_CODE) begin
      return off[GLYPH_W-1:0];
    end
    return '0;
  endfunction

  function automatic logic [7:0] glyph_column(input logic [39:0] glyph,
                                              input logic [COL_W-1:0] col);
    logic [7:0] b;
    case (col)
      3'd0:    b = glyph[39:32];
      3'd1:    b = glyph[31:24];
      3'd2:    b = glyph[23:16];
      3'd3:    b = glyph[15:8];
      3'd4:    b = glyph[7:0];
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

@@ hdl/ltbg_bcd.sv @@
// Request pipeline: number saturation and three stages of binary to decimal conversion.
module ltbg_bcd (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  ltbg_pkg::stage_t in_req_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output ltbg_pkg::req_t  out_req_o
);

  localparam int STAGES = 4;

  logic [STAGES-1:0]      valid_q;
  logic [STAGES-1:0]      valid_d;
  logic [STAGES-1:0]      adv;
  ltbg_pkg::stage_t       data_q [STAGES];
  ltbg_pkg::stage_t       data_d [STAGES];
  logic [ltbg_pkg::BIN_W-1:0] num_sat;

  always_comb begin
    adv[STAGES-1] = !valid_q[STAGES-1] || out_ready_i;
    for (int i = STAGES - 2; i >= 0; i--) begin
      adv[i] = !valid_q[i] || adv[i+1];
    end
  end

  assign in_ready_o = adv[0];
  assign valid_d    = {valid_q[STAGES-2:0], in_valid_i};

  always_comb begin
    num_sat = in_req_i.work[ltbg_pkg::BIN_W-1:0];
    if (num_sat > ltbg_pkg::NUMBER_MAX) begin
      num_sat = ltbg_pkg::NUMBER_MAX;
    end
    data_d[0]      = in_req_i;
    data_d[0].work = {{ltbg_pkg::BCD_W{1'b0}}, num_sat};
    data_d[1]      = data_q[0];
    data_d[1].work = ltbg_pkg::dabble_run(data_q[0].work, ltbg_pkg::STEPS_A);
    data_d[2]      = data_q[1];
    data_d[2].work = ltbg_pkg::dabble_run(data_q[1].work, ltbg_pkg::STEPS_B);
    data_d[3]      = data_q[2];
    data_d[3].work = ltbg_pkg::dabble_run(data_q[2].work, ltbg_pkg::STEPS_C);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      for (int i = 0; i < STAGES; i++) begin
        if (adv[i]) begin
          valid_q[i] <= valid_d[i];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < STAGES; i++) begin
      if (adv[i]) begin
        data_q[i] <= data_d[i];
      end
    end
  end

  assign out_valid_o          = valid_q[STAGES-1];
  assign out_req_o.command    = data_q[STAGES-1].command;
  assign out_req_o.byte_value = data_q[STAGES-1].byte_value;
  assign out_req_o.column     = data_q[STAGES-1].column;
  assign out_req_o.row        = data_q[STAGES-1].row;
  assign out_req_o.digits     =
    data_q[STAGES-1].work[ltbg_pkg::WORK_W-1 -: ltbg_pkg::BCD_W];

  a_saturated: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[0] |-> data_q[0].work[ltbg_pkg::BIN_W-1:0] <= ltbg_pkg::NUMBER_MAX)
    else $error("saturated number out of range");

  a_digits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_req_o.digits[15:12] <= ltbg_pkg::DIGIT_MAX) &&
                    (out_req_o.digits[11:8] <= ltbg_pkg::DIGIT_MAX) &&
                    (out_req_o.digits[7:4] <= ltbg_pkg::DIGIT_MAX) &&
                    (out_req_o.digits[3:0] <= ltbg_pkg::DIGIT_MAX))
    else $error("decimal digit above nine");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[STAGES-1] && !out_ready_i |=> valid_q[STAGES-1])
    else $error("stalled request lost");

endmodule

@@ hdl/ltbg_emit.sv @@
// Byte sequencer with font lookup and output register.
module ltbg_emit (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  ltbg_pkg::req_t in_req_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [7:0]     out_byte_o,
  output logic           out_is_data_o,
  output logic           out_last_o
);

  logic                             busy_q, busy_d;
  ltbg_pkg::req_t                   req_q, req_d;
  logic [ltbg_pkg::COL_W-1:0]       col_q, col_d;
  logic [ltbg_pkg::DIG_W-1:0]       digit_q, digit_d;
  logic [ltbg_pkg::GLYPH_W-1:0]     glyph_q, glyph_d;
  logic                             out_valid_q, out_valid_d;
  logic [7:0]                       out_byte_q;
  logic                             out_data_q, out_last_q;
  logic                             step, load;
  logic [7:0]                       cur_byte, glyph_byte;
  logic                             cur_data, cur_last;
  logic                             col_end;

  assign step       = busy_q && (!out_valid_q || out_ready_i);
  assign glyph_byte = ltbg_pkg::glyph_column(ltbg_pkg::GLYPH_ROM[glyph_q], col_q);
  assign col_end    = (col_q == ltbg_pkg::COL_W'(ltbg_pkg::GLYPH_WIDTH));

  always_comb begin
    cur_byte = 8'h00;
    cur_data = 1'b0;
    cur_last = 1'b1;
    case (req_q.command)
      ltbg_pkg::CMD_RAW_CMD: begin
        cur_byte = req_q.byte_value;
      end
      ltbg_pkg::CMD_RAW_DATA: begin
        cur_byte = req_q.byte_value;
        cur_data = 1'b1;
      end
      ltbg_pkg::CMD_CHAR: begin
        cur_byte = glyph_byte;
        cur_data = 1'b1;
        cur_last = col_end;
      end
      ltbg_pkg::CMD_CURSOR: begin
        cur_byte = (col_q == '0) ? (ltbg_pkg::SET_COLUMN | {1'b0, req_q.column})
                                 : (ltbg_pkg::SET_ROW | {5'b0, req_q.row});
        cur_last = (col_q != '0);
      end
      ltbg_pkg::CMD_NUMBER: begin
        cur_byte = glyph_byte;
        cur_data = 1'b1;
        cur_last = col_end && (digit_q == ltbg_pkg::DIG_W'(ltbg_pkg::DIGIT_COUNT - 1));
      end
      default: begin
        cur_byte = 8'h00;
      end
    endcase
  end

  assign in_ready_o = !busy_q || (step && cur_last);
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    busy_d  = busy_q;
    req_d   = req_q;
    col_d   = col_q;
    digit_d = digit_q;
    glyph_d = glyph_q;
    if (step) begin
      if (cur_last) begin
        busy_d = 1'b0;
      end else if (col_end) begin
        col_d        = '0;
        digit_d      = digit_q + 1'b1;
        req_d.digits = req_q.digits << 4;
        glyph_d      = ltbg_pkg::ZERO_GLYPH +
                       ltbg_pkg::GLYPH_W'(req_q.digits[ltbg_pkg::BCD_W-5 -: 4]);
      end else begin
        col_d = col_q + 1'b1;
      end
    end
    if (load) begin
      // drop unused commands: they give no bytes
      busy_d  = (in_req_i.command <= ltbg_pkg::CMD_NUMBER);
      req_d   = in_req_i;
      col_d   = '0;
      digit_d = '0;
      if (in_req_i.command == ltbg_pkg::CMD_NUMBER) begin
        glyph_d = ltbg_pkg::ZERO_GLYPH +
                  ltbg_pkg::GLYPH_W'(in_req_i.digits[ltbg_pkg::BCD_W-1 -: 4]);
      end else begin
        glyph_d = ltbg_pkg::glyph_index(in_req_i.byte_value);
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (step) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q   <= req_d;
    col_q   <= col_d;
    digit_q <= digit_d;
    glyph_q <= glyph_d;
    if (step) begin
      out_byte_q <= cur_byte;
      out_data_q <= cur_data;
      out_last_q <= cur_last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_byte_o    = out_byte_q;
  assign out_is_data_o = out_data_q;
  assign out_last_o    = out_last_q;

  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> col_q <= ltbg_pkg::COL_W'(ltbg_pkg::GLYPH_WIDTH))
    else $error("column counter out of range");

  a_cursor_two: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && req_q.command == ltbg_pkg::CMD_CURSOR |-> col_q <= 1)
    else $error("cursor move beyond two bytes");

  a_digit_number: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && digit_q != '0 |-> req_q.command == ltbg_pkg::CMD_NUMBER)
    else $error("digit counter moved outside a number request");

endmodule

@@ hdl/lcd_text_byte_generator.sv @@
// Top level of the LCD text byte generator: stream ports, request pipeline and byte sequencer.
//
// Each accepted request passes four register stages (number saturation, then three
// binary to decimal stages) and a byte sequencer that drives one output byte per cycle,
// while the output port accepts bytes, into the output register. The output port sets the
// pace: a raw request gives one byte, a cursor move two, a character six and a number
// twenty-four; commands 5 to 7 give no bytes. Requests are taken every cycle while the
// pipeline has room, also while a byte waits at the output.
module lcd_text_byte_generator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // byte_value[7:0], column[14:8], row[17:15], number[31:18]
  input  logic [2:0]  s_axis_tuser,   // command[2:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // out_byte[7:0]
  output logic        m_axis_tuser,   // is_data[0]
  output logic        m_axis_tlast
);

  ltbg_pkg::stage_t in_req;
  ltbg_pkg::req_t   mid_req;
  logic             mid_valid, mid_ready;

  assign in_req.command    = ltbg_pkg::cmd_e'(s_axis_tuser);
  assign in_req.byte_value = s_axis_tdata[7:0];
  assign in_req.column     = s_axis_tdata[14:8];
  assign in_req.row        = s_axis_tdata[17:15];
  assign in_req.work       = {{ltbg_pkg::BCD_W{1'b0}}, s_axis_tdata[31:18]};

  ltbg_bcd u_bcd (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_req_i    (in_req),
    .out_valid_o (mid_valid),
    .out_ready_i (mid_ready),
    .out_req_o   (mid_req)
  );

  ltbg_emit u_emit (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (mid_valid),
    .in_ready_o    (mid_ready),
    .in_req_i      (mid_req),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_byte_o    (m_axis_tdata),
    .out_is_data_o (m_axis_tuser),
    .out_last_o    (m_axis_tlast)
  );

endmodule
